[hw/rtl/hrml_pkg.sv]
`default_nettype none

package hrml_pkg;

  localparam int unsigned PosW = 4;

  localparam logic [PosW-1:0] PosStart = 4'd0;
  localparam logic [PosW-1:0] PosAddr  = 4'd3;
  localparam logic [PosW-1:0] PosKind  = 4'd7;
  localparam logic [PosW-1:0] PosData  = 4'd9;
  localparam logic [PosW-1:0] PosLow   = 4'd10;

  localparam logic [7:0] ChCr   = 8'd13;
  localparam logic [7:0] ChLf   = 8'd10;
  localparam logic [7:0] KindData = 8'd0;

  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        bad;
  } hrml_res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hrml_hex_t;

  function automatic hrml_hex_t hex_decode(input logic [7:0] c);
    hrml_hex_t h;
    logic [7:0] d;
    h.bad = 1'b0;
    d = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      d = c - 8'd48;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      d = c - 8'd55;
    end else if (c >= 8'd97 && c <= 8'd102) begin
      d = c - 8'd87;
    end else begin
      h.bad = 1'b1;
    end
    h.nib = d[3:0];
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hex_record_memory_loader_core.sv]
// channel | ports                                             | dir
// in      | in_valid, in_stall, in_ch                         | char beats in
// out     | out_valid, out_stall, out_write_addr/_data, bad   | write beats out
// one character a cycle unless in_stall; a low data digit registers a write
// the parser state is updated once per accepted beat
// rst_n is synchronous and returns the parser to the start of a line
// a two-deep output (register plus skid) lets input run while out is stalled;
// in_stall rises only when the skid entry holds a write
`default_nettype none

module hex_record_memory_loader_core
  import hrml_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_write_addr,
  output logic [7:0]       out_write_data,
  output logic             out_bad_digit
);

  hrml_res_t res;
  logic      in_fire;
  logic      out_free;
  logic      out_valid_r;
  logic      skid_v_r;
  logic [15:0] out_addr_r, skid_addr_r;
  logic [7:0]  out_data_r, skid_data_r;
  logic        out_bad_r, skid_bad_r;

  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !skid_v_r;
  assign out_free = !out_valid_r || !out_stall;

  hrml_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .ch    (in_ch),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        out_addr_r  <= skid_addr_r;
        out_data_r  <= skid_data_r;
        out_bad_r   <= skid_bad_r;
        skid_v_r    <= 1'b0;
      end else if (in_fire && res.valid) begin
        out_valid_r <= 1'b1;
        out_addr_r  <= res.addr;
        out_data_r  <= res.data;
        out_bad_r   <= res.bad;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (in_fire && res.valid) begin
      skid_v_r    <= 1'b1;
      skid_addr_r <= res.addr;
      skid_data_r <= res.data;
      skid_bad_r  <= res.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_write_addr = out_addr_r;
  assign out_write_data = out_data_r;
  assign out_bad_digit  = out_bad_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry held with no output beat");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled while output was free");
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!skid_v_r && !out_stall))
    else $error("output beat dropped");
`endif

endmodule

`default_nettype wire

[hw/rtl/hrml_parser.sv]
`default_nettype none

module hrml_parser
  import hrml_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] ch,
  output hrml_res_t       res
);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        hi_bad_r, hi_bad_nxt;
  hrml_hex_t   hx;
  logic        line_end;

  assign hx = hex_decode(ch);
  assign line_end = (ch == ChCr) || (ch == ChLf);

  always_comb begin
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    hi_nxt     = hi_r;
    hi_bad_nxt = hi_bad_r;
    res.valid  = 1'b0;
    res.addr   = addr_r;
    res.data   = {hi_r, hx.nib};
    res.bad    = hi_bad_r | hx.bad;
    priority if (line_end) begin
      pos_nxt    = PosStart;
      count_nxt  = '0;
      addr_nxt   = '0;
      kind_nxt   = '0;
      left_nxt   = '0;
      hi_nxt     = '0;
      hi_bad_nxt = 1'b0;
    end else if (pos_r == PosStart) begin
      pos_nxt = pos_r + 4'd1;
    end else if (pos_r < PosAddr) begin
      count_nxt = {count_r[3:0], hx.nib};
      pos_nxt   = pos_r + 4'd1;
    end else if (pos_r < PosKind) begin
      addr_nxt = {addr_r[11:0], hx.nib};
      pos_nxt  = pos_r + 4'd1;
    end else if (pos_r < PosData) begin
      kind_nxt = {kind_r[3:0], hx.nib};
      pos_nxt  = pos_r + 4'd1;
      if (pos_nxt == PosData) begin
        left_nxt = (kind_nxt == KindData) ? count_r : 8'd0;
      end
    end else if (pos_r == PosData) begin
      hi_nxt     = hx.nib;
      hi_bad_nxt = hx.bad;
      pos_nxt    = PosLow;
    end else begin
      pos_nxt = PosData;
      if (left_r != 8'd0) begin
        res.valid = 1'b1;
        addr_nxt  = addr_r + 16'd1;
        left_nxt  = left_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= PosStart;
      count_r  <= '0;
      addr_r   <= '0;
      kind_r   <= '0;
      left_r   <= '0;
      hi_r     <= '0;
      hi_bad_r <= 1'b0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      kind_r   <= kind_nxt;
      left_r   <= left_nxt;
      hi_r     <= hi_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

`ifndef SYNTH
  a_res_only_low: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (pos_r == PosLow && left_r != 8'd0 && !line_end))
    else $error("write raised outside a low data digit");
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && line_end) |=> (pos_r == PosStart && left_r == 8'd0))
    else $error("line end did not clear the parser");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= PosLow) && (left_r == 8'd0 || pos_r >= PosData))
    else $error("position or byte count out of step");
`endif

endmodule

`default_nettype wire
